// File: design/exbs_pkg.sv
// Shared types and constants for the unwind-index range search block.
package exbs_pkg;

    // Field widths of the stream payloads.
    localparam int unsigned IDX_W  = 10;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned CNT_W  = 11;

    // Input item kinds carried on the slave tuser bit.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Configuration register indexes.
    localparam logic REG_TABLE_BASE  = 1'b0;
    localparam logic REG_ENTRY_COUNT = 1'b1;

    // One search result as handed from the search engine to the output stage.
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  match_index;
        logic [WORD_W-1:0] function_start;
    } t_result;

endpackage

// File: design/exbs_table.sv
// Start-address table: one write port and two registered read ports.
module exbs_table #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [exbs_pkg::WORD_W-1:0] i_wr_data,
    input  logic [AW-1:0]              i_rd_addr0,
    input  logic [AW-1:0]              i_rd_addr1,
    output logic [exbs_pkg::WORD_W-1:0] o_rd_data0,
    output logic [exbs_pkg::WORD_W-1:0] o_rd_data1
);

    logic [exbs_pkg::WORD_W-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Two registered read ports; the data for an address appears in the next cycle.
    always_ff @(posedge i_clk) begin
        o_rd_data0 <= r_mem[i_rd_addr0];
        o_rd_data1 <= r_mem[i_rd_addr1];
    end

endmodule

// File: design/exbs_search.sv
// Binary search engine: walks the start table one probe per cycle.
module exbs_search #(
    parameter int unsigned MAX_ENTRIES = 1024,
    parameter int unsigned AW          = 10,
    parameter int unsigned NW          = 11
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [exbs_pkg::WORD_W-1:0] i_lookup_address,
    input  logic [NW-1:0]               i_nrec,
    input  logic                        i_res_ready,
    input  logic [exbs_pkg::WORD_W-1:0] i_rd_data0,
    input  logic [exbs_pkg::WORD_W-1:0] i_rd_data1,
    output logic                        o_idle,
    output logic                        o_res_valid,
    output exbs_pkg::t_result           o_res,
    output logic [AW-1:0]               o_rd_addr0,
    output logic [AW-1:0]               o_rd_addr1
);

    // Probe limit is the bit length of the table depth.
    localparam int unsigned LIM = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned PW  = $clog2(LIM + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_RESULT = 3'b100
    } t_state;

    t_state                      r_state, n_state;
    logic [NW-1:0]               r_left, n_left;
    logic [NW-1:0]               r_right, n_right;
    logic [NW-1:0]               r_mid, n_mid;
    logic [NW-1:0]               r_nrec, n_nrec;
    logic [PW-1:0]               r_probes, n_probes;
    logic [exbs_pkg::WORD_W-1:0] r_addr, n_addr;
    exbs_pkg::t_result           r_res, n_res;

    logic          w_below;
    logic          w_within;
    logic          w_last;
    logic [NW-1:0] w_left;
    logic [NW-1:0] w_right;
    logic [PW-1:0] w_probes_nx;
    logic [NW:0]   w_sum;

    // Probe evaluation on the words read for the current midpoint.
    always_comb begin
        w_last      = (r_mid == (r_nrec - NW'(1)));
        w_below     = (r_addr < i_rd_data0);
        w_within    = w_last || (i_rd_data1 == '0) || (r_addr < i_rd_data1);
        w_left      = r_left;
        w_right     = r_right;
        if (w_below) begin
            w_right = r_mid - NW'(1);
        end else if (!w_within) begin
            w_left = r_mid + NW'(1);
        end
        w_probes_nx = r_probes + PW'(1);
    end

    // Next-state logic; the next midpoint feeds the table read ports directly.
    always_comb begin
        n_state  = r_state;
        n_left   = r_left;
        n_right  = r_right;
        n_mid    = r_mid;
        n_nrec   = r_nrec;
        n_probes = r_probes;
        n_addr   = r_addr;
        n_res    = r_res;
        w_sum    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_nrec   = i_nrec;
                    n_addr   = i_lookup_address;
                    n_left   = '0;
                    n_right  = i_nrec - NW'(1);
                    n_mid    = n_right >> 1;
                    n_probes = '0;
                    n_res    = '0;
                    n_state  = (i_nrec == '0) ? S_RESULT : S_SEARCH;
                end
            end
            S_SEARCH: begin
                n_probes = w_probes_nx;
                n_left   = w_left;
                n_right  = w_right;
                w_sum    = {1'b0, w_left} + {1'b0, w_right};
                n_mid    = NW'(w_sum >> 1);
                if (w_below && (r_mid == r_left)) begin
                    n_state = S_RESULT;
                end else if (!w_below && w_within) begin
                    n_res.found          = 1'b1;
                    n_res.match_index    = exbs_pkg::IDX_W'(r_mid);
                    n_res.function_start = i_rd_data0;
                    n_state              = S_RESULT;
                end else if ((w_probes_nx >= PW'(LIM)) || (w_left > w_right)) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state is reset; datapath registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left   <= n_left;
        r_right  <= n_right;
        r_mid    <= n_mid;
        r_nrec   <= n_nrec;
        r_probes <= n_probes;
        r_addr   <= n_addr;
        r_res    <= n_res;
    end

    // Read the midpoint entry and its successor for the next probe.
    assign o_rd_addr0  = AW'(n_mid);
    assign o_rd_addr1  = AW'(n_mid + NW'(1));
    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESULT);
    assign o_res       = r_res;

endmodule

// File: design/exidx_range_binary_search_core.sv
// Top level of the unwind-index range search block: config, streams, table and search.
//
//  Channel     | Direction | Handshake               | Payload
//  ------------+-----------+-------------------------+-------------------------------------
//  s_axis      | in        | tvalid / tready         | tuser op, tdata index/offset/address
//  m_axis      | out       | tvalid / tready         | tuser found, tdata index/start
//  APB         | in        | psel/penable, pready=1  | table_base at 0x0, entry_count at 0x4
//
// A load transaction writes the table as it is accepted and the block is ready again at once.
// A lookup runs P probes and then hands its result on to the output register, where P is the
// number of probes, at most clog2(MAX_ENTRIES + 1); each probe reads two adjacent table
// words through the two read ports together. The next transaction is taken once the
// result has moved into the output register, even while m_axis is stalled.
// Reset is synchronous and active low; the table contents are not cleared.
module exidx_range_binary_search_core #(
    parameter int unsigned MAX_ENTRIES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // entry_index[9:0], offset_word[41:10],
                                        // lookup_address[73:42], zero pad
    input  logic        s_axis_tuser,   // op[0]
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // match_index[9:0], function_start[41:10], zero pad
    output logic        m_axis_tuser,   // found[0]
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned NW = (CW > exbs_pkg::CNT_W) ? CW : exbs_pkg::CNT_W;

    logic [exbs_pkg::WORD_W-1:0] r_table_base;
    logic [exbs_pkg::CNT_W-1:0]  r_entry_count;
    logic                        r_out_valid;
    exbs_pkg::t_result           r_out;

    logic                        w_in_acc;
    logic                        w_op;
    logic [exbs_pkg::IDX_W-1:0]  w_entry_index;
    logic [exbs_pkg::WORD_W-1:0] w_offset_word;
    logic [exbs_pkg::WORD_W-1:0] w_lookup_address;
    logic [exbs_pkg::WORD_W-1:0] w_resolved;
    logic                        w_wr_en;
    logic [NW-1:0]               w_nrec;
    logic                        w_idle;
    logic                        w_res_valid;
    logic                        w_res_ready;
    exbs_pkg::t_result           w_res;
    logic [AW-1:0]               w_rd_addr0;
    logic [AW-1:0]               w_rd_addr1;
    logic [exbs_pkg::WORD_W-1:0] w_rd_data0;
    logic [exbs_pkg::WORD_W-1:0] w_rd_data1;
    logic                        w_cfg_wr;

    // Configuration registers.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_base  <= '0;
            r_entry_count <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                exbs_pkg::REG_TABLE_BASE:  r_table_base  <= pwdata;
                exbs_pkg::REG_ENTRY_COUNT: r_entry_count <= pwdata[exbs_pkg::CNT_W-1:0];
                default:                   r_table_base  <= r_table_base;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            exbs_pkg::REG_TABLE_BASE:  prdata = r_table_base;
            exbs_pkg::REG_ENTRY_COUNT: prdata = 32'(r_entry_count);
            default:                   prdata = '0;
        endcase
    end

    // Input unpacking.
    assign w_op             = s_axis_tuser;
    assign w_entry_index    = s_axis_tdata[9:0];
    assign w_offset_word    = s_axis_tdata[41:10];
    assign w_lookup_address = s_axis_tdata[73:42];
    assign s_axis_tready    = w_idle;
    assign w_in_acc         = s_axis_tvalid && s_axis_tready;

    // Load path: sign-extend the prel31 word and add the entry's own address.
    assign w_resolved = {w_offset_word[30], w_offset_word[30:0]} + r_table_base
                      + (32'(w_entry_index) << 3);
    assign w_wr_en    = w_in_acc && (w_op == exbs_pkg::OP_LOAD)
                      && (32'(w_entry_index) < 32'(MAX_ENTRIES));

    // Effective entry count, clamped to the table depth.
    assign w_nrec = (NW'(r_entry_count) > NW'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES)
                                                            : NW'(r_entry_count);

    exbs_table #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_table (
        .i_clk      (i_clk),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (AW'(w_entry_index)),
        .i_wr_data  (w_resolved),
        .i_rd_addr0 (w_rd_addr0),
        .i_rd_addr1 (w_rd_addr1),
        .o_rd_data0 (w_rd_data0),
        .o_rd_data1 (w_rd_data1)
    );

    exbs_search #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW),
        .NW          (NW)
    ) u_search (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (w_in_acc && (w_op == exbs_pkg::OP_LOOKUP)),
        .i_lookup_address (w_lookup_address),
        .i_nrec           (w_nrec),
        .i_res_ready      (w_res_ready),
        .i_rd_data0       (w_rd_data0),
        .i_rd_data1       (w_rd_data1),
        .o_idle           (w_idle),
        .o_res_valid      (w_res_valid),
        .o_res            (w_res),
        .o_rd_addr0       (w_rd_addr0),
        .o_rd_addr1       (w_rd_addr1)
    );

    // Output register decouples the search from the output stream.
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.found;
    assign m_axis_tdata  = {6'b0, r_out.function_start, r_out.match_index};

    // A lookup transaction keeps the input closed on the following cycle.
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !s_axis_tready)
        else $error("input accepted while a lookup is in progress");

    // A miss carries a zero index and a zero start address.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("not-found result with nonzero payload");

    // A hit names an entry inside the valid part of the table.
    a_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (NW'(r_out.match_index) < w_nrec))
        else $error("hit index beyond entry count");

endmodule
